>>> sv/sbsr_pkg.sv
`default_nettype none

package sbsr_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned MAX_RESULTS = 3;

   typedef enum logic {
      DIR_PACK   = 1'b0,
      DIR_UNPACK = 1'b1
   } direction_type;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       no_data;
      logic       last_out;
   } rsp_item_type;

   // Everything one input item produces, queued as one unit.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [1:0]                  count;
      logic                        no_data;
      logic                        last;
   } group_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

>>> sv/sbsr_front.sv
`default_nettype none

module sbsr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire sbsr_pkg::req_item_type req_payload,
   input  wire sbsr_pkg::queue_status_type q_status,
   output logic                       push,
   output sbsr_pkg::group_type        push_group
);

   sbsr_pkg::direction_type direction_ff, direction_in;
   logic [6:0]  acc_ff, acc_in;
   logic [3:0]  bits_ff, bits_in;

   logic [14:0] wide_pack;
   logic [13:0] wide_unp;
   logic [4:0]  tot_pack;
   logic [4:0]  tot_unp;
   logic [14:0] sh0;
   logic [14:0] sh1;
   logic [13:0] shu;
   logic [14:0] flush;
   logic [4:0]  rem5;
   logic [3:0]  rem;
   logic [7:0]  mask;
   logic [6:0]  low_bits;
   logic        accept;
   sbsr_pkg::group_type grp;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign wide_pack = {acc_ff, req_payload.data_in};
   assign wide_unp  = {acc_ff, req_payload.data_in[6:0]};
   assign tot_pack  = {1'b0, bits_ff} + 5'd8;
   assign tot_unp   = {1'b0, bits_ff} + 5'd7;
   assign sh0       = wide_pack >> (tot_pack - 5'd7);
   assign sh1       = wide_pack >> (tot_pack - 5'd14);
   assign shu       = wide_unp >> (tot_unp - 5'd8);

   always_comb begin
      grp  = '0;
      rem5 = '0;
      if (direction_ff == sbsr_pkg::DIR_PACK) begin
         if (tot_pack >= 5'd14) begin
            rem5        = tot_pack - 5'd14;
            grp.data[0] = {1'b0, sh0[6:0]};
            grp.data[1] = {1'b0, sh1[6:0]};
            grp.count   = 2'd2;
         end else begin
            rem5        = tot_pack - 5'd7;
            grp.data[0] = {1'b0, sh0[6:0]};
            grp.count   = 2'd1;
         end
      end else begin
         if (tot_unp >= 5'd8) begin
            rem5        = tot_unp - 5'd8;
            grp.data[0] = shu[7:0];
            grp.count   = 2'd1;
         end else begin
            rem5 = tot_unp;
            if (req_payload.last_in) begin
               grp.no_data = 1'b1;
               grp.count   = 2'd1;
            end
         end
      end
      rem = rem5[3:0];

      flush = wide_pack << (4'd7 - rem);
      if (direction_ff == sbsr_pkg::DIR_PACK && req_payload.last_in && rem != 4'd0) begin
         if (grp.count == 2'd2) begin
            grp.data[2] = {1'b0, flush[6:0]};
         end else begin
            grp.data[1] = {1'b0, flush[6:0]};
         end
         grp.count = grp.count + 2'd1;
      end
      grp.last = req_payload.last_in;
   end

   assign mask     = (8'd1 << rem) - 8'd1;
   assign low_bits = (direction_ff == sbsr_pkg::DIR_PACK) ? wide_pack[6:0] : wide_unp[6:0];

   always_comb begin
      direction_in = direction_ff;
      acc_in       = acc_ff;
      bits_in      = bits_ff;
      if (csr_wr_en) begin
         direction_in = sbsr_pkg::direction_type'(csr_wr_data);
         acc_in       = '0;
         bits_in      = '0;
      end else if (accept) begin
         if (req_payload.last_in) begin
            acc_in  = '0;
            bits_in = '0;
         end else begin
            acc_in  = low_bits & mask[6:0];
            bits_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= sbsr_pkg::DIR_PACK;
         acc_ff       <= '0;
         bits_ff      <= '0;
      end else begin
         direction_ff <= direction_in;
         acc_ff       <= acc_in;
         bits_ff      <= bits_in;
      end
   end

   assign push       = accept && grp.count != 2'd0;
   assign push_group = grp;

endmodule

`default_nettype wire

>>> sv/sbsr_queue.sv
`default_nettype none

module sbsr_queue #(
   parameter int unsigned DEPTH = sbsr_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sbsr_pkg::group_type push_group,
   input  wire logic                pop,
   output sbsr_pkg::group_type      head,
   output sbsr_pkg::queue_status_type status
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   sbsr_pkg::group_type entries_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == CntW'(DEPTH);

endmodule

`default_nettype wire

>>> sv/sbsr_back.sv
`default_nettype none

module sbsr_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sbsr_pkg::group_type        head,
   input  wire sbsr_pkg::queue_status_type q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output sbsr_pkg::rsp_item_type          rsp_payload
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sbsr_pkg::rsp_item_type rsp_ff, rsp_in;
   logic       take;
   logic       load;
   logic       final_one;

   assign take      = !rsp_valid_ff || rsp_ready;
   assign load      = take && q_status.not_empty;
   assign final_one = idx_ff == (head.count - 2'd1);
   assign pop       = load && final_one;

   always_comb begin
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      rsp_in.data_out = head.data[idx_ff];
      rsp_in.no_data  = head.no_data;
      rsp_in.last_out = head.last && final_one;
      if (take) begin
         rsp_valid_in = q_status.not_empty;
      end
      if (!load) begin
         rsp_in = rsp_ff;
      end else if (final_one) begin
         idx_in = '0;
      end else begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_marker_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.no_data |-> rsp_ff.last_out && rsp_ff.data_out == 8'd0)
      else $error("marker-only result must be final and carry zero data");

   a_mid_group_holds_head: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> q_status.not_empty && idx_ff < head.count)
      else $error("result index points outside the queued group");

   a_no_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty && take)
      else $error("group retired without a transfer slot");

endmodule

`default_nettype wire

>>> sv/seven_bit_stream_repacker.sv
`default_nettype none

// Regroups a byte stream as one MSB-first bitstream: in pack direction each
// byte yields one or two 7-bit groups, and a last byte with bits left over
// adds a zero-padded flush group; in unpack direction each 7-bit group adds
// to a byte emitted once eight bits are pending, and a last group that ends
// no byte yields a marker-only result. The front stage takes one item per
// cycle while the group queue has room, so the input side never waits on the
// output beyond that queue. The output register sends one result per cycle
// while rsp_ready allows; an item makes none or one result in unpack
// direction, one or two in pack direction (eight results per seven bytes,
// plus one for a flush). Results pass the group queue, then the output
// register. Writing csr_wr_data sets the direction and clears any pending
// bits; it is meant to happen only while the block is idle.
module seven_bit_stream_repacker #(
   parameter int unsigned QUEUE_DEPTH = sbsr_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sbsr_pkg::req_item_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output sbsr_pkg::rsp_item_type      rsp_payload
);

   logic                       push;
   logic                       pop;
   sbsr_pkg::group_type        push_group;
   sbsr_pkg::group_type        head;
   sbsr_pkg::queue_status_type q_status;

   sbsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_group  (push_group)
   );

   sbsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   sbsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> bench/sbsr_checker.sv
`default_nettype none

module sbsr_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_wr_data,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire sbsr_pkg::req_item_type req_payload,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire sbsr_pkg::rsp_item_type rsp_payload,
   output int                          mismatches,
   output int                          outstanding,
   output int                          checked,
   output int                          markers
);
   timeunit 1ns;
   timeprecision 1ps;

   sbsr_pkg::direction_type dir_q;
   logic [13:0]             stream_bits;
   int unsigned             stream_len;
   sbsr_pkg::rsp_item_type  regrouped_q[$];
   int                      error_total;
   int                      checked_total;
   int                      marker_total;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
      markers     = 0;
      error_total   = 0;
      checked_total = 0;
      marker_total  = 0;
      dir_q       = sbsr_pkg::DIR_PACK;
      stream_bits = '0;
      stream_len  = 0;
   end

   task automatic queue_result(input sbsr_pkg::rsp_item_type item);
      regrouped_q.insert(regrouped_q.size(), item);
   endtask

   task automatic regroup_transfer(input sbsr_pkg::req_item_type item);
      logic [21:0]            work;
      int unsigned            fill;
      int                     produced;
      sbsr_pkg::rsp_item_type group;
      work     = {8'd0, stream_bits};
      fill     = stream_len;
      produced = 0;
      if (fill > 7) begin
         fill = 7;
      end
      if (dir_q == sbsr_pkg::DIR_PACK) begin
         work = (work << 8) | 22'(item.data_in);
         fill += 8;
         while (fill >= 7) begin
            fill -= 7;
            group.data_out = 8'((work >> fill) & 22'h7f);
            group.no_data  = 1'b0;
            group.last_out = 1'b0;
            queue_result(group);
            produced++;
         end
         if (item.last_in && fill > 0) begin
            group.data_out = 8'((work << (7 - fill)) & 22'h7f);
            group.no_data  = 1'b0;
            group.last_out = 1'b0;
            queue_result(group);
            produced++;
         end
      end else begin
         work = (work << 7) | 22'(item.data_in[6:0]);
         fill += 7;
         if (fill >= 8) begin
            fill -= 8;
            group.data_out = 8'((work >> fill) & 22'hff);
            group.no_data  = 1'b0;
            group.last_out = 1'b0;
            queue_result(group);
            produced++;
         end
         if (item.last_in && produced == 0) begin
            group.data_out = 8'd0;
            group.no_data  = 1'b1;
            group.last_out = 1'b0;
            queue_result(group);
            produced++;
         end
      end
      if (item.last_in) begin
         group = regrouped_q.pop_back();
         group.last_out = 1'b1;
         queue_result(group);
         stream_bits = '0;
         stream_len  = 0;
      end else begin
         stream_bits = 14'(work & ((22'd1 << fill) - 22'd1));
         stream_len  = fill;
      end
   endtask

   always @(posedge clock) begin
      sbsr_pkg::rsp_item_type want;
      if (reset) begin
         dir_q       = sbsr_pkg::DIR_PACK;
         stream_bits = '0;
         stream_len  = 0;
         regrouped_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (regrouped_q.size() == 0) begin
               $display("%0t: unexpected result transfer, actual %p", $time, rsp_payload);
               error_total++;
            end else begin
               want = regrouped_q.pop_front();
               checked_total++;
               if (want.no_data) begin
                  marker_total++;
               end
               if (rsp_payload.data_out !== want.data_out) begin
                  $display("%0t: data_out expected %02h actual %02h",
                           $time, want.data_out, rsp_payload.data_out);
                  error_total++;
               end
               if (rsp_payload.no_data !== want.no_data) begin
                  $display("%0t: no_data expected %b actual %b",
                           $time, want.no_data, rsp_payload.no_data);
                  error_total++;
               end
               if (rsp_payload.last_out !== want.last_out) begin
                  $display("%0t: last_out expected %b actual %b",
                           $time, want.last_out, rsp_payload.last_out);
                  error_total++;
               end
            end
         end
         if (csr_wr_en) begin
            dir_q       = sbsr_pkg::direction_type'(csr_wr_data);
            stream_bits = '0;
            stream_len  = 0;
         end
         if (req_valid && req_ready) begin
            regroup_transfer(req_payload);
         end
      end
      mismatches  <= error_total;
      outstanding <= regrouped_q.size();
      checked     <= checked_total;
      markers     <= marker_total;
   end

endmodule

`default_nettype wire

>>> bench/tb_seven_bit_stream_repacker.sv
`default_nettype none

module tb_seven_bit_stream_repacker;
   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic                    csr_wr_data = 1'b0;
   logic                    req_valid   = 1'b0;
   logic                    rsp_ready   = 1'b0;
   sbsr_pkg::req_item_type  req_payload = '0;
   wire logic               req_ready;
   wire logic               rsp_valid;
   sbsr_pkg::rsp_item_type  rsp_payload;

   int            mismatches;
   int            outstanding;
   int            checked;
   int            markers;

   sbsr_pkg::direction_type cur_dir = sbsr_pkg::DIR_PACK;
   int            pack_items      = 0;
   int            unpack_items    = 0;
   int            csr_writes      = 0;
   int            rsp_transfers   = 0;
   int            idle_cycles     = 0;
   bit            sender_bursty   = 1'b0;
   bit            receiver_bursty = 1'b0;

   seven_bit_stream_repacker u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   sbsr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .markers     (markers)
   );

   always #4 clock = ~clock;

   function automatic int unsigned draw_gap(input bit bursty);
      return bursty ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic send_item(input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = draw_gap(sender_bursty);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_in: data, last_in: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cur_dir == sbsr_pkg::DIR_PACK) begin
         pack_items++;
      end else begin
         unpack_items++;
      end
   endtask

   // The block may still hold an unpack transfer that yields nothing, so
   // let it settle before the write.
   task automatic set_direction(input sbsr_pkg::direction_type dir);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dir;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_dir = dir;
      csr_writes++;
   endtask

   initial begin
      int unsigned phase_items;
      int unsigned len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hA5, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hC3, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'h5A, 1'b1);

      set_direction(sbsr_pkg::DIR_UNPACK);
      send_item(8'h7F, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'h2A, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h7F, 1'b1);
      send_item(8'h7F, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(8'h40, 1'b0);
      send_item(8'h3F, 1'b1);
      send_item(8'h12, 1'b0);
      set_direction(sbsr_pkg::DIR_UNPACK);
      send_item(8'h7F, 1'b1);

      set_direction(sbsr_pkg::DIR_PACK);
      send_item(8'h80, 1'b0);
      set_direction(sbsr_pkg::DIR_PACK);
      send_item(8'h01, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         set_direction(sbsr_pkg::direction_type'(phase[0] ^ 1'b1));
         phase_items = 0;
         while (phase_items < 22) begin
            sender_bursty = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
               len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(1, 8);
               for (int unsigned i = 0; i < len; i++) begin
                  send_item(8'($urandom_range(0, 255)), i == len - 1);
               end
               phase_items += len;
            end else begin
               send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
               phase_items++;
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d pack and %0d unpack transfers across %0d direction writes.",
               pack_items, unpack_items, csr_writes);
      $display("Checked %0d results, %0d of them marker-only.", checked, markers);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // One long hold-off lets the block fill up and stall its input.
   initial begin
      int unsigned stall;
      bit          held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && rsp_transfers == 80) begin
            held  = 1'b1;
            stall = 300;
         end else begin
            stall = draw_gap(receiver_bursty);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsp_transfers++;
         if (rsp_transfers % 40 == 0) begin
            receiver_bursty = ($urandom_range(0, 3) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 2000) begin
            $display("Timed out with no transfer for %0d cycles.", idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
